@@ design/ctr_pkg.sv @@
// Package for the color token recognizer: sizes, character codes and the color name ROM.
// No dependencies. It is used by ctr_name_match and color_token_recognizer.
`timescale 1ns / 1ps
package ctr_pkg;

	localparam int MAX_RAW_CHARS = 47;
	localparam int NAME_COUNT    = 40;
	localparam int RAW_CNT_W     = $clog2(MAX_RAW_CHARS + 1);
	localparam int BODY_LEN_W    = 6;
	localparam int BODY_LEN_MAX  = (1 << BODY_LEN_W) - 1;
	localparam int HEX_DIGITS    = 6;
	localparam int RGB_W         = 24;
	localparam int NAME_MAX_LEN  = 9;
	localparam int NAME_LEN_W    = $clog2(NAME_MAX_LEN + 1);
	localparam int NAME_TXT_W    = NAME_MAX_LEN * 8;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	// Names are right-justified in their slot, first character in the highest used byte.
	localparam logic [NAME_TXT_W-1:0] NAME_TXT [NAME_COUNT] = '{
		"black", "white", "red", "green", "blue", "yellow", "cyan", "magenta",
		"purple", "orange", "pink", "gray", "off", "grey", "lime", "teal",
		"navy", "maroon", "olive", "aqua", "fuchsia", "indigo", "violet", "gold",
		"silver", "brown", "beige", "coral", "salmon", "chocolate", "crimson",
		"turquoise", "skyblue", "lavender", "mint", "peach", "hotpink", "plum",
		"orchid", "khaki"
	};

	localparam logic [NAME_LEN_W-1:0] NAME_LEN [NAME_COUNT] = '{
		4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7,
		4'd6, 4'd6, 4'd4, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4,
		4'd4, 4'd6, 4'd5, 4'd4, 4'd7, 4'd6, 4'd6, 4'd4,
		4'd6, 4'd5, 4'd5, 4'd5, 4'd6, 4'd9, 4'd7,
		4'd9, 4'd7, 4'd8, 4'd4, 4'd5, 4'd7, 4'd4,
		4'd6, 4'd5
	};

	localparam logic [RGB_W-1:0] NAME_RGB [NAME_COUNT] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
		24'h00FFFF, 24'hFF00FF, 24'h800080, 24'hFFA500, 24'hFFC0CB, 24'h808080,
		24'h000000, 24'h808080, 24'hBFFF00, 24'h008080, 24'h000080, 24'h800000,
		24'h808000, 24'h00FFFF, 24'hFF00FF, 24'h4B0082, 24'hEE82EE, 24'hFFD700,
		24'hC0C0C0, 24'hCC9B65, 24'hF5F5DC, 24'hFF7F50, 24'hFA8072,
		24'hD2691E, 24'hDC143C,
		24'h40E0D0, 24'h87CEEB,
		24'hE6E6FA, 24'h98FF98, 24'hFFDAB9,
		24'hFF69B4, 24'hDDA0DD, 24'hDA70D6,
		24'hF0E68C
	};

	typedef struct packed {
		logic [NAME_COUNT-1:0] cand;
		logic                  hit;
		logic [RGB_W-1:0]      rgb;
	} ctr_match_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Character of name idx at position pos; NUL past the end (a body byte is never NUL).
	function automatic logic [7:0] name_char(input int idx, input logic [BODY_LEN_W-1:0] pos);
		logic [NAME_LEN_W-1:0] off;
		logic [NAME_TXT_W-1:0] sh;
		off = '0;
		sh  = '0;
		if (pos >= BODY_LEN_W'(NAME_LEN[idx])) begin
			return CH_NUL;
		end
		off = NAME_LEN[idx] - NAME_LEN_W'(1) - pos[NAME_LEN_W-1:0];
		sh  = NAME_TXT[idx] >> {off, 3'b000};
		return sh[7:0];
	endfunction

endpackage

@@ design/ctr_name_match.sv @@
// Parallel compare of one body character against every ROM name, plus the final pick.
// Depends on ctr_pkg.
`timescale 1ns / 1ps
module ctr_name_match (
	input  logic [ctr_pkg::NAME_COUNT-1:0] cand,
	input  logic                           take,
	input  logic [ctr_pkg::BODY_LEN_W-1:0] pos,
	input  logic [7:0]                     ch,
	input  logic [ctr_pkg::BODY_LEN_W-1:0] final_len,
	output ctr_pkg::ctr_match_t            match
);
	import ctr_pkg::*;

	logic [NAME_COUNT-1:0] keep;

	// lowest index wins
	always_comb begin
		keep = cand;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (take && (name_char(i, pos) != ch)) begin
				keep[i] = 1'b0;
			end
		end
		match.cand = keep;
		match.hit  = 1'b0;
		match.rgb  = '0;
		for (int i = NAME_COUNT - 1; i >= 0; i--) begin
			if (keep[i] && (final_len == BODY_LEN_W'(NAME_LEN[i]))) begin
				match.hit = 1'b1;
				match.rgb = NAME_RGB[i];
			end
		end
	end

endmodule

@@ design/color_token_recognizer.sv @@
// Color token recognizer: one byte per request, one color result per token.
// The result is registered once the last byte leaves the input register.
// Throughput: one byte per cycle; a held result stalls the input only once a further
// last byte waits in the input register.
// Reset (arst_n low, asynchronous) clears the token state and empties both registers.
// Depends on ctr_pkg and ctr_name_match.
`timescale 1ns / 1ps
module color_token_recognizer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       char_valid,
	output logic                       char_ready,
	input  logic [7:0]                 char_code,
	input  logic                       token_end,
	output logic                       color_valid,
	input  logic                       color_ready,
	output logic [ctr_pkg::RGB_W-1:0]  rgb_color,
	output logic                       is_invalid
);
	import ctr_pkg::*;

	logic                  s1_valid;
	logic [7:0]            s1_char;
	logic                  s1_last;

	logic                  in_body_q, ended_q, pend_q, bad_q, hex_ok_q;
	logic [RAW_CNT_W-1:0]  raw_q;
	logic [BODY_LEN_W-1:0] len_q;
	logic [NAME_COUNT-1:0] cand_q;
	logic [RGB_W-1:0]      hex_q;

	logic                  in_body_nx, ended_nx, pend_nx, bad_nx, hex_ok_nx;
	logic [RAW_CNT_W-1:0]  raw_nx;
	logic [BODY_LEN_W-1:0] len_nx;
	logic [RGB_W-1:0]      hex_nx;

	logic                  body_char, take;
	logic [7:0]            folded;
	ctr_match_t            match;

	logic                  advance, load;
	logic                  found;
	logic [RGB_W-1:0]      res_rgb;
	logic                  out_valid_q, out_inv_q;
	logic [RGB_W-1:0]      out_rgb_q;

	assign advance    = s1_valid && (!s1_last || !out_valid_q || color_ready);
	assign load       = advance && s1_last;
	assign char_ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (char_ready) begin
			s1_valid <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			s1_char <= char_code;
			s1_last <= token_end;
		end
	end

	// byte classification and state update
	always_comb begin
		in_body_nx = in_body_q;
		ended_nx   = ended_q;
		pend_nx    = pend_q;
		bad_nx     = bad_q;
		hex_ok_nx  = hex_ok_q;
		raw_nx     = raw_q;
		len_nx     = len_q;
		hex_nx     = hex_q;
		body_char  = 1'b0;
		take       = 1'b0;
		folded     = s1_char;
		if (s1_char >= CH_UA && s1_char <= CH_UZ) begin
			folded = s1_char | 8'h20;
		end
		if (!ended_q && (raw_q < RAW_CNT_W'(MAX_RAW_CHARS))) begin
			if (s1_char == CH_NUL) begin
				ended_nx = 1'b1;
			end else begin
				raw_nx = raw_q + RAW_CNT_W'(1);
				if (!in_body_q) begin
					if (!is_space(s1_char)) begin
						in_body_nx = 1'b1;
						body_char  = (s1_char != CH_HASH);
					end
				end else begin
					body_char = 1'b1;
				end
			end
		end
		if (body_char) begin
			if (is_space(s1_char) || s1_char == CH_COMMA || s1_char == CH_HASH) begin
				pend_nx = 1'b1;
			end else begin
				take = 1'b1;
				if (pend_q) begin
					bad_nx = 1'b1;
				end
				if (len_q >= BODY_LEN_W'(HEX_DIGITS)) begin
					hex_ok_nx = 1'b0;
				end else if (folded >= CH_0 && folded <= CH_9) begin
					hex_nx = {hex_q[RGB_W-5:0], folded[3:0]};
				end else if (folded >= CH_LA && folded <= CH_LF) begin
					hex_nx = {hex_q[RGB_W-5:0], folded[3:0] + 4'd9};
				end else begin
					hex_ok_nx = 1'b0;
				end
				if (len_q != BODY_LEN_W'(BODY_LEN_MAX)) begin
					len_nx = len_q + BODY_LEN_W'(1);
				end
			end
		end
	end

	ctr_name_match u_match (
		.cand      (cand_q),
		.take      (take),
		.pos       (len_q),
		.ch        (folded),
		.final_len (len_nx),
		.match     (match)
	);

	always_comb begin
		found   = 1'b0;
		res_rgb = '0;
		if (!bad_nx && len_nx != '0) begin
			if (match.hit) begin
				found   = 1'b1;
				res_rgb = match.rgb;
			end else if (hex_ok_nx && len_nx == BODY_LEN_W'(HEX_DIGITS)) begin
				found   = 1'b1;
				res_rgb = hex_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			ended_q   <= 1'b0;
			pend_q    <= 1'b0;
			bad_q     <= 1'b0;
			hex_ok_q  <= 1'b1;
			raw_q     <= '0;
			len_q     <= '0;
			cand_q    <= '1;
			hex_q     <= '0;
		end else if (load) begin
			in_body_q <= 1'b0;
			ended_q   <= 1'b0;
			pend_q    <= 1'b0;
			bad_q     <= 1'b0;
			hex_ok_q  <= 1'b1;
			raw_q     <= '0;
			len_q     <= '0;
			cand_q    <= '1;
			hex_q     <= '0;
		end else if (advance) begin
			in_body_q <= in_body_nx;
			ended_q   <= ended_nx;
			pend_q    <= pend_nx;
			bad_q     <= bad_nx;
			hex_ok_q  <= hex_ok_nx;
			raw_q     <= raw_nx;
			len_q     <= len_nx;
			cand_q    <= match.cand;
			hex_q     <= hex_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (color_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_rgb_q <= res_rgb;
			out_inv_q <= !found;
		end
	end

	assign color_valid = out_valid_q;
	assign rgb_color   = out_rgb_q;
	assign is_invalid  = out_inv_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_inv_q |-> out_rgb_q == '0)
		else $error("invalid result carries a nonzero color");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> len_q == '0 && raw_q == '0 && !in_body_q && cand_q == '1)
		else $error("token state not cleared after result");

	a_raw_limit: assert property (@(posedge clk) disable iff (!arst_n)
		raw_q <= RAW_CNT_W'(MAX_RAW_CHARS) && len_q <= BODY_LEN_W'(raw_q))
		else $error("byte counters out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !color_ready && s1_valid && s1_last |-> !advance)
		else $error("result register overwritten while held");

endmodule
